FILE: src/igfr_pkg.sv
package igfr_pkg;

  // Frame store geometry
  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int TICKS_W = 8;
  localparam int OUT_W   = 16;

  localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 8'd4;
  localparam logic [CNT_W-1:0]   FULL_CNT         = CNT_W'(FRAME_DEPTH);

  // Item kind carried on in_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage

FILE: src/igfr_ram.sv
module igfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/idle_gap_frame_receiver_unit.sv
// Idle-gap frame receiver.
// Input stream: each beat is either a received byte (in_tuser = 0, byte in
// in_tdata) or one time tick (in_tuser = 1). Bytes are written in order into
// a 64-entry frame store; every byte reloads the idle countdown from the
// cfg register (0 acts as 1). Bytes beyond a full store are dropped but still
// reload the countdown. Ticks count the countdown down; when it hits zero the
// frame is closed and read out.
// Output stream: one beat per stored byte, in arrival order, with the frame
// length in out_tdata[14:8] and out_tlast on the final byte.
// Timing: byte and tick beats are taken back to back while collecting. A closing
// tick starts the readout, which walks the store through the RAM read port
// one byte per cycle while out_tready stays high: the closing tick moves the FSM
// to drain, a read is issued from the read index, and its data is registered
// into the output queue. in_tready is low from the closing tick until the last
// byte is taken, so the input waits for the whole readout of a frame.
// Stall: a two-entry output queue (output register plus skid) absorbs the
// registered RAM read; reads are only issued when a slot is guaranteed,
// so out_tready can drop at any time without loss.
// Reset: fill count, countdown and readout control clear; cfg returns to 4.
// The store itself is not cleared; only written entries are ever read.
module idle_gap_frame_receiver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  input  logic                        in_tuser,   // [0] op
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [7:0] frame_byte, [14:8] frame_length
  output logic                        out_tlast,  // last
  // config
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data // idle_ticks
);

  igfr_pkg::state_t state_r, state_nxt;

  logic [igfr_pkg::TICKS_W-1:0] idle_ticks_r;
  logic [igfr_pkg::TICKS_W-1:0] countdown_r, countdown_nxt;
  logic [igfr_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [igfr_pkg::CNT_W-1:0]   len_r, len_nxt;
  logic [igfr_pkg::CNT_W-1:0]   rd_idx_r, rd_idx_nxt;

  // read in flight, and its last flag
  logic rd_pend_r;
  logic rd_pend_last_r;

  // output queue: head register and skid entry
  logic                         head_valid_r, head_valid_nxt;
  logic [igfr_pkg::BYTE_W-1:0]  head_byte_r, head_byte_nxt;
  logic                         head_last_r, head_last_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  logic [igfr_pkg::BYTE_W-1:0]  skid_byte_r, skid_byte_nxt;
  logic                         skid_last_r, skid_last_nxt;

  logic                        accept;
  logic                        is_byte;
  logic                        is_tick;
  logic                        frame_close;
  logic                        drain_active;
  logic                        pop;
  logic                        push;
  logic [1:0]                  occ_pend;
  logic                        slot_free;
  logic                        issue;
  logic                        issue_last;
  logic                        wr_en;
  logic [igfr_pkg::BYTE_W-1:0] rd_data;

  assign accept  = in_tvalid && in_tready;
  assign is_byte = accept && (in_tuser == igfr_pkg::OP_BYTE);
  assign is_tick = accept && (in_tuser == igfr_pkg::OP_TICK);

  // Countdown expires on this tick; an empty store gives no frame.
  assign frame_close = is_tick && (countdown_r == igfr_pkg::TICKS_W'(1))
                       && (fill_r != '0);

  assign wr_en = is_byte && (fill_r < igfr_pkg::FULL_CNT);

  // ---------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      igfr_pkg::ST_COLLECT: begin
        if (frame_close) begin
          state_nxt = igfr_pkg::ST_DRAIN;
        end
      end
      igfr_pkg::ST_DRAIN: begin
        if (pop && head_last_r) begin
          state_nxt = igfr_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = igfr_pkg::ST_COLLECT;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_tready    = 1'b0;
    drain_active = 1'b0;
    unique case (state_r)
      igfr_pkg::ST_COLLECT: in_tready    = 1'b1;
      igfr_pkg::ST_DRAIN:   drain_active = 1'b1;
      default: begin
        in_tready    = 1'b0;
        drain_active = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Collect side: fill count, countdown, frame length capture
  // ---------------------------------------------------------------
  always_comb begin
    fill_nxt      = fill_r;
    countdown_nxt = countdown_r;
    len_nxt       = len_r;
    if (is_byte) begin
      if (wr_en) begin
        fill_nxt = igfr_pkg::CNT_W'(fill_r + 1'b1);
      end
      countdown_nxt = (idle_ticks_r == '0) ? igfr_pkg::TICKS_W'(1) : idle_ticks_r;
    end else if (is_tick && (countdown_r != '0)) begin
      countdown_nxt = igfr_pkg::TICKS_W'(countdown_r - 1'b1);
      if (countdown_r == igfr_pkg::TICKS_W'(1)) begin
        fill_nxt = '0;
        len_nxt  = fill_r;
      end
    end
  end

  // ---------------------------------------------------------------
  // Readout: issue reads only when the output queue has room for them
  // ---------------------------------------------------------------
  assign pop  = head_valid_r && out_tready;
  assign push = rd_pend_r;

  assign occ_pend  = 2'({1'b0, head_valid_r}) + 2'({1'b0, skid_valid_r})
                   + 2'({1'b0, rd_pend_r});
  assign slot_free = (occ_pend == 2'd0) || (occ_pend == 2'd1)
                     || (pop && (occ_pend == 2'd2));

  assign issue      = drain_active && (rd_idx_r != len_r) && slot_free;
  assign issue_last = (rd_idx_r == igfr_pkg::CNT_W'(len_r - 1'b1));

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (frame_close) begin
      rd_idx_nxt = '0;
    end else if (issue) begin
      rd_idx_nxt = igfr_pkg::CNT_W'(rd_idx_r + 1'b1);
    end
  end

  // Output queue update
  always_comb begin
    head_valid_nxt = head_valid_r;
    head_byte_nxt  = head_byte_r;
    head_last_nxt  = head_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_byte_nxt  = skid_byte_r;
    skid_last_nxt  = skid_last_r;
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_valid_nxt = 1'b1;
        head_byte_nxt  = skid_byte_r;
        head_last_nxt  = skid_last_r;
        skid_valid_nxt = push;
        skid_byte_nxt  = rd_data;
        skid_last_nxt  = rd_pend_last_r;
      end else begin
        head_valid_nxt = push;
        head_byte_nxt  = rd_data;
        head_last_nxt  = rd_pend_last_r;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_byte_nxt  = rd_data;
      skid_last_nxt  = rd_pend_last_r;
    end
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= igfr_pkg::ST_COLLECT;
      idle_ticks_r <= igfr_pkg::IDLE_TICKS_RESET;
      countdown_r  <= '0;
      fill_r       <= '0;
      len_r        <= '0;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        idle_ticks_r <= cfg_wr_data;
      end
      countdown_r  <= countdown_nxt;
      fill_r       <= fill_nxt;
      len_r        <= len_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_pend_r    <= issue;
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    rd_pend_last_r <= issue_last;
    head_byte_r    <= head_byte_nxt;
    head_last_r    <= head_last_nxt;
    skid_byte_r    <= skid_byte_nxt;
    skid_last_r    <= skid_last_nxt;
  end

  // Frame store. Writes only while collecting, reads only while draining,
  // so the ports never touch the same entry in the same cycle.
  igfr_ram #(
    .WIDTH (igfr_pkg::BYTE_W),
    .DEPTH (igfr_pkg::FRAME_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[igfr_pkg::ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (issue),
    .rd_addr (rd_idx_r[igfr_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign out_tvalid = head_valid_r;
  assign out_tdata  = {1'b0, igfr_pkg::LEN_W'(len_r), head_byte_r};
  assign out_tlast  = head_last_r;

endmodule

FILE: src/igfr_checker.sv
module igfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // no input taken while a frame is being read out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during readout");

  // a frame carries at least one byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:8] != 7'd0)
    else $error("zero frame length");

  // readout continues until the last byte is taken
  a_frame_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("readout ended before last byte");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind idle_gap_frame_receiver_unit igfr_checker u_igfr_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // One frame beat as the block should deliver it.
  typedef struct {
    logic [igfr_pkg::BYTE_W-1:0] frame_byte;
    logic [igfr_pkg::LEN_W-1:0]  frame_length;
    logic                        last;
  } frame_beat_t;

  // Mirror of the receiver: frame store, fill count, idle countdown and the
  // idle_ticks register. Accepted input beats advance it; every closed
  // frame pushes its readout beats onto frame_beats_due.
  class frame_scoreboard;
    logic [igfr_pkg::BYTE_W-1:0]  frame_mem [igfr_pkg::FRAME_DEPTH];
    int unsigned                  fill;
    logic [igfr_pkg::TICKS_W-1:0] countdown;
    logic [igfr_pkg::TICKS_W-1:0] idle_ticks;
    frame_beat_t                  frame_beats_due [$];
    int unsigned                  errors;
    int unsigned                  dropped;
    int unsigned                  frames_seen;

    function new();
      fill        = 0;
      countdown   = '0;
      idle_ticks  = igfr_pkg::IDLE_TICKS_RESET;
      errors      = 0;
      dropped     = 0;
      frames_seen = 0;
    endfunction

    function void write_idle_ticks(logic [igfr_pkg::TICKS_W-1:0] value);
      idle_ticks = value;
    endfunction

    function void note_input(logic op, logic [igfr_pkg::BYTE_W-1:0] rx_byte);
      frame_beat_t fb;
      if (op == igfr_pkg::OP_BYTE) begin
        if (fill < igfr_pkg::FRAME_DEPTH) begin
          frame_mem[fill] = rx_byte;
          fill++;
        end else begin
          dropped++;
        end
        // a zero register still closes one tick after the byte
        countdown = (idle_ticks == 0) ? igfr_pkg::TICKS_W'(1) : idle_ticks;
      end else if (countdown != 0) begin
        countdown = countdown - 1'b1;
        if (countdown == 0) begin
          for (int i = 0; i < fill; i++) begin
            fb.frame_byte   = frame_mem[i];
            fb.frame_length = igfr_pkg::LEN_W'(fill);
            fb.last         = (i == fill - 1);
            frame_beats_due.push_back(fb);
          end
          fill = 0;
        end
      end
    endfunction

    function void check_result(logic [igfr_pkg::OUT_W-1:0] tdata, logic tlast);
      frame_beat_t fb;
      if (frame_beats_due.size() == 0) begin
        $error("unexpected frame beat: tdata=%h tlast=%b", tdata, tlast);
        errors++;
        return;
      end
      fb = frame_beats_due.pop_front();
      if (tdata[7:0] !== fb.frame_byte) begin
        $error("frame_byte: expected %0h, got %0h", fb.frame_byte, tdata[7:0]);
        errors++;
      end
      if (tdata[14:8] !== fb.frame_length) begin
        $error("frame_length: expected %0d, got %0d", fb.frame_length, tdata[14:8]);
        errors++;
      end
      if (tlast !== fb.last) begin
        $error("last: expected %b, got %b", fb.last, tlast);
        errors++;
      end
      if (tdata[15] !== 1'b0) begin
        $error("tdata pad: expected 0, got %b", tdata[15]);
        errors++;
      end
      if (fb.last) frames_seen++;
    endfunction

    function int unsigned beats_due();
      return frame_beats_due.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int SETTLE      = 6;     // hold-off before a register write
  localparam int TAIL        = 24;    // drain time after the last result

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [7:0]                   in_tdata;
  logic                         in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [igfr_pkg::OUT_W-1:0]   out_tdata;
  logic                         out_tlast;
  logic                         cfg_wr_en;
  logic [igfr_pkg::TICKS_W-1:0] cfg_wr_data;

  frame_scoreboard              sb = new();
  int unsigned                  send_idle_pct;
  int unsigned                  recv_stall_pct;
  int unsigned                  beats_in;
  logic [igfr_pkg::TICKS_W-1:0] cur_ticks;

  idle_gap_frame_receiver_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: sample at the rising edge, pick the next ready level at
  // the falling edge.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // One input beat. valid only drops when a gap is actually taken, so a
  // back-to-back stream keeps it high across beats.
  task automatic send_beat(input logic op, input logic [7:0] rx_byte);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = rx_byte;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, rx_byte);
    beats_in++;
  endtask

  // Tick payload is don't-care, so it gets random bits too.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(igfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending until every predicted frame beat has been taken.
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.beats_due() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_idle_ticks(input logic [igfr_pkg::TICKS_W-1:0] value);
    hold_until_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.write_idle_ticks(value);
    cur_ticks = value;
  endtask

  // A frame of len random bytes, sometimes with ticks between bytes that
  // stay short of the timeout; closed by exactly enough ticks when asked.
  task automatic send_frame(input int unsigned len, input bit close_it);
    int unsigned eff;
    int unsigned k;
    eff = (cur_ticks == 0) ? 1 : cur_ticks;
    for (int i = 0; i < len; i++) begin
      send_beat(igfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      if (i < len - 1 && eff > 1 && $urandom_range(0, 99) < 20) begin
        k = $urandom_range(1, (eff - 1 < 3) ? eff - 1 : 3);
        send_ticks(k);
      end
    end
    if (close_it) send_ticks(eff);
  endtask

  task automatic run_phase(input logic [igfr_pkg::TICKS_W-1:0] ticks,
                           input int unsigned sidle,
                           input int unsigned rstall, input int unsigned n_beats,
                           input bit overfull);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    write_idle_ticks(ticks);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    start = beats_in;
    // full-store frame: bytes past 64 are dropped but still reload
    if (overfull) begin
      send_frame($urandom_range(igfr_pkg::FRAME_DEPTH, igfr_pkg::FRAME_DEPTH + 2), 1'b1);
    end
    while (beats_in - start < n_beats) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r   = $urandom_range(0, 99);
        len = (r < 60) ? $urandom_range(1, 4) :
              (r < 90) ? $urandom_range(5, 16) : $urandom_range(17, 24);
        send_frame(len, 1'b1);
        if ($urandom_range(0, 99) < 8) hold_until_drained();
      end else if (r < 93) begin
        // left open: the next bytes join this frame
        send_frame($urandom_range(1, 3), 1'b0);
      end else begin
        // stray ticks, mostly against an idle countdown
        send_ticks($urandom_range(1, 2));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = igfr_pkg::OP_BYTE;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_in       = 0;
    cur_ticks      = igfr_pkg::IDLE_TICKS_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, on the reset value of idle_ticks (4).
    send_ticks(1);                           // tick with countdown already zero
    send_beat(igfr_pkg::OP_BYTE, 8'h00);
    send_beat(igfr_pkg::OP_BYTE, 8'hFF);
    send_ticks(3);                           // one short of the timeout
    send_beat(igfr_pkg::OP_BYTE, 8'hA5);     // reloads the countdown
    send_ticks(4);                           // closes a three-byte frame
    write_idle_ticks(8'd0);                  // zero behaves as one
    send_beat(igfr_pkg::OP_BYTE, 8'h5A);
    send_ticks(1);
    send_ticks(1);                           // idle again: no result
    write_idle_ticks(8'd1);
    send_beat(igfr_pkg::OP_BYTE, 8'h80);
    send_beat(igfr_pkg::OP_BYTE, 8'h7F);
    send_ticks(1);

    // Random phases, walking through the idle/stall mixes.
    run_phase(8'd2, 0, 0, 12, 1'b0);
    run_phase(8'd2, 55, 0, 10, 1'b1);
    run_phase(8'($urandom_range(3, 6)), 0, 55, 12, 1'b0);
    run_phase(8'd3, 29, 29, 12, 1'b0);

    // Widest timeout: a byte loads 255 and a few ticks leave the frame
    // open; the next phase's first byte reloads from the new value.
    write_idle_ticks(8'd255);
    send_beat(igfr_pkg::OP_BYTE, 8'hC3);
    send_ticks(3);

    run_phase(8'd0, 29, 29, 10, 1'b0);
    run_phase(8'd1, 55, 55, 10, 1'b0);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.beats_due() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d input beats (%0d bytes dropped on a full store); checked %0d frames.",
             beats_in, sb.dropped, sb.frames_seen);
    $display("idle_ticks ran at reset value, 0, 1, 2..6, plus a 255 reload, under mixed idle and stall.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
